### design/assert_macros.svh
// Shared assertion forms for the labeler checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check while out of reset.
`define CHK_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check at every edge, reset included.
`define CHK_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### design/nclab_pkg.sv
package nclab_pkg;

    localparam int DEF_MAX_CLUSTERS = 8;
    localparam int DEF_MAX_DIMS     = 16;

    localparam int FEAT_W        = 16;
    localparam int SQ_W          = 34;
    localparam int SUM_W         = 37;
    localparam int DIST_W        = 36;
    localparam int LABEL_W       = 3;
    localparam int CLUSTER_IDX_W = 6;
    localparam int K_W           = 4;

    localparam logic [K_W-1:0] K_RESET = 4'd8;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_POINT = 1'b1;

    typedef struct packed {
        logic              command;
        logic [2:0]        cluster_index;
        logic [3:0]        feature_index;
        logic [FEAT_W-1:0] feature_value;
        logic              point_end;
    } in_item_t;

    typedef struct packed {
        logic [LABEL_W-1:0] label;
        logic [DIST_W-1:0]  best_distance;
    } out_item_t;

    // Broadcast from the front end to every cell
    typedef struct packed {
        logic              wr_en;
        logic              rd_en;
        logic [2:0]        cluster;
        logic [FEAT_W-1:0] value;
    } feat_bus_t;

    // Running minimum handed along the cell row
    typedef struct packed {
        logic                     valid;
        logic [CLUSTER_IDX_W-1:0] idx;
        logic [SUM_W-1:0]         sum;
    } token_t;

endpackage

### design/nearest_centroid_labeler_core.sv
// channel | direction | handshake            | payload
// in      | in        | in_valid / in_ready  | in_data (in_item_t)
// out     | out       | out_valid / out_ready| out_data (out_item_t)
// cfg     | in        | cfg_wr_en            | cfg_wr_data (active_clusters)
//
// Loads and point features are taken one per cycle while in_ready is high;
// each cell reads its own centroid row, squares and accumulates over a
// three-stage pipeline. In_ready drops on a point's last feature until the
// minimum token has walked the cell row, longer if out is stalled.
// Reset clears the running sums and control at once; centroid rows are
// not cleared and must be loaded before use.
module nearest_centroid_labeler_core
    import nclab_pkg::*;
#(
    parameter int MAX_CLUSTERS = DEF_MAX_CLUSTERS,
    parameter int MAX_DIMS     = DEF_MAX_DIMS,
    localparam int AW          = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  in_item_t       in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output out_item_t      out_data,
    input  logic           cfg_wr_en,
    input  logic [K_W-1:0] cfg_wr_data
);

    logic [K_W-1:0]          k_reg;
    logic                    busy_reg;
    logic                    s1_valid_reg;
    logic                    s1_last_reg;
    logic [FEAT_W-1:0]       s1_x_reg;
    logic                    s2_last_reg;
    logic                    launch_reg;
    logic                    out_valid_reg;
    logic [LABEL_W-1:0]      label_reg;
    logic [DIST_W-1:0]       dist_reg;
    logic                    accept;
    logic                    feat_ok;
    logic                    hold;
    logic                    deliver;
    logic [AW-1:0]           addr;
    logic [MAX_CLUSTERS-1:0] active;
    feat_bus_t               bus;
    token_t                  chain [MAX_CLUSTERS+1];

    assign in_ready = !busy_reg;
    assign accept   = in_valid && in_ready;
    assign feat_ok  = 32'(in_data.feature_index) < MAX_DIMS;
    assign addr     = AW'(in_data.feature_index);

    assign bus.wr_en   = accept && (in_data.command == CMD_LOAD) && feat_ok;
    assign bus.rd_en   = accept && (in_data.command == CMD_POINT) && feat_ok;
    assign bus.cluster = in_data.cluster_index;
    assign bus.value   = in_data.feature_value;

    // k of zero acts as one; cells past MAX_CLUSTERS do not exist
    always_comb
    begin
        for (int i = 0; i < MAX_CLUSTERS; i++)
        begin
            active[i] = (i == 0) || (32'(i) < {{(32 - K_W){1'b0}}, k_reg});
        end
    end

    assign chain[0].valid = launch_reg;
    assign chain[0].idx   = '0;
    assign chain[0].sum   = '0;

    assign hold    = chain[MAX_CLUSTERS].valid && out_valid_reg && !out_ready;
    assign deliver = chain[MAX_CLUSTERS].valid && !hold;

    for (genvar g = 0; g < MAX_CLUSTERS; g++)
    begin : g_cell
        nclab_cell #(
            .MAX_DIMS (MAX_DIMS),
            .CELL_ID  (g)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .bus       (bus),
            .addr      (addr),
            .acc_valid (s1_valid_reg),
            .acc_x     (s1_x_reg),
            .active    (active[g]),
            .hold      (hold),
            .tin_first (g == 0),
            .tin       (chain[g]),
            .tout      (chain[g+1])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg         <= K_RESET;
            busy_reg      <= 1'b0;
            s1_valid_reg  <= 1'b0;
            s1_last_reg   <= 1'b0;
            s2_last_reg   <= 1'b0;
            launch_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                k_reg <= cfg_wr_data;
            end
            s1_valid_reg <= bus.rd_en;
            s1_last_reg  <= accept && (in_data.command == CMD_POINT) && in_data.point_end;
            s2_last_reg  <= s1_last_reg;
            launch_reg   <= s2_last_reg;
            // hold off input from a point end until its label is handed over
            if (accept && (in_data.command == CMD_POINT) && in_data.point_end)
            begin
                busy_reg <= 1'b1;
            end
            else if (deliver)
            begin
                busy_reg <= 1'b0;
            end
            if (deliver)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_x_reg <= in_data.feature_value;
        end
        if (deliver)
        begin
            label_reg <= chain[MAX_CLUSTERS].idx[LABEL_W-1:0];
            dist_reg  <= chain[MAX_CLUSTERS].sum[SUM_W-1] ? '1
                                                          : chain[MAX_CLUSTERS].sum[DIST_W-1:0];
        end
    end

    assign out_valid              = out_valid_reg;
    assign out_data.label         = label_reg;
    assign out_data.best_distance = dist_reg;

endmodule

### design/nclab_cell.sv
module nclab_cell
    import nclab_pkg::*;
#(
    parameter int MAX_DIMS = DEF_MAX_DIMS,
    parameter int CELL_ID  = 0,
    localparam int AW      = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  feat_bus_t         bus,
    input  logic [AW-1:0]     addr,
    input  logic              acc_valid,
    input  logic [FEAT_W-1:0] acc_x,
    input  logic              active,
    input  logic              hold,
    input  logic              tin_first,
    input  token_t            tin,
    output token_t            tout
);

    logic [FEAT_W-1:0]        mem [MAX_DIMS];
    logic [FEAT_W-1:0]        rd_data_reg;
    logic [SQ_W-1:0]          sq_reg;
    logic [SQ_W-1:0]          sq_next;
    logic [SUM_W-1:0]         sum_reg;
    logic [SUM_W-1:0]         sum_next;
    logic                     tout_valid_reg;
    logic [CLUSTER_IDX_W-1:0] tout_idx_reg;
    logic [SUM_W-1:0]         tout_sum_reg;
    logic signed [16:0]       diff;
    logic signed [33:0]       prod;
    logic [SUM_W:0]           acc;
    logic                     take_own;
    logic                     step;

    always_ff @(posedge clk)
    begin
        if (bus.wr_en && (32'(bus.cluster) == CELL_ID))
        begin
            mem[addr] <= bus.value;
        end
        if (bus.rd_en)
        begin
            rd_data_reg <= mem[addr];
        end
    end

    always_comb
    begin
        diff    = $signed({acc_x[FEAT_W-1], acc_x})
                - $signed({rd_data_reg[FEAT_W-1], rd_data_reg});
        prod    = diff * diff;
        sq_next = (acc_valid && active) ? SQ_W'(unsigned'(prod)) : '0;
    end

    assign step     = tin.valid && !hold;
    assign acc      = {1'b0, sum_reg} + {{(SUM_W + 1 - SQ_W){1'b0}}, sq_reg};
    assign take_own = active && (tin_first || (sum_reg < tin.sum));

    always_comb
    begin
        if (step)
        begin
            // token has read this sum: clear for the next point
            sum_next = '0;
        end
        else if (acc[SUM_W])
        begin
            sum_next = '1;
        end
        else
        begin
            sum_next = acc[SUM_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_reg         <= '0;
            sum_reg        <= '0;
            tout_valid_reg <= 1'b0;
        end
        else
        begin
            sq_reg  <= sq_next;
            sum_reg <= sum_next;
            if (!hold)
            begin
                tout_valid_reg <= tin.valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            if (take_own)
            begin
                tout_idx_reg <= CLUSTER_IDX_W'(CELL_ID);
                tout_sum_reg <= sum_reg;
            end
            else
            begin
                tout_idx_reg <= tin.idx;
                tout_sum_reg <= tin.sum;
            end
        end
    end

    assign tout.valid = tout_valid_reg;
    assign tout.idx   = tout_idx_reg;
    assign tout.sum   = tout_sum_reg;

endmodule

### design/nclab_checker.sv
`include "assert_macros.svh"

module nclab_checker
    import nclab_pkg::*;
(
    input logic           clk,
    input logic           rst_n,
    input logic           in_valid,
    input logic           in_ready,
    input in_item_t       in_data,
    input logic           out_valid,
    input logic           out_ready,
    input out_item_t      out_data
);

    `CHK_ASSERT(a_out_hold, (out_valid && !out_ready |=> out_valid && $stable(out_data)), "stalled result changed")
    `CHK_ASSERT_ALWAYS(a_rst_quiet, (!rst_n |-> !out_valid), "result shown in reset")
    `CHK_ASSERT(a_end_blocks, (in_valid && in_ready && (in_data.command == CMD_POINT) && in_data.point_end |=> !in_ready), "input taken during label search")
    `CHK_ASSERT(a_result_after_search, ($rose(out_valid) |-> $past(!in_ready)), "result without a finished point")

endmodule

bind nearest_centroid_labeler_core nclab_checker u_nclab_checker (.*);
